// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is released
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ebrmd_pkg.sv
// ---------------------------------------------------------------------------
// ebrmd_pkg
// Types, widths and constants of the block energy-ratio mute detector.
// ---------------------------------------------------------------------------
package ebrmd_pkg;

  // sample and energy widths
  localparam int SAMPLE_W    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int ENERGY_W    = 48;

  // configuration
  localparam int FPB_W       = 16;
  localparam int FLOOR_W     = 40;
  localparam int THR_W       = 10;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = FLOOR_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESH = 2'd2;

  localparam logic [FPB_W-1:0]   FPB_RESET    = 16'd4800;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET  = 40'd30680000;
  localparam logic [THR_W-1:0]   THRESH_RESET = 10'd18;

  // decision window
  localparam int LOOK_BACK  = 5;
  localparam int LOOK_AHEAD = 9;
  localparam int WIN_W      = LOOK_BACK + LOOK_AHEAD + 1;
  localparam int OWED_W     = $clog2(LOOK_AHEAD + 2);
  localparam int IDX_W      = 32;

  // loudness test: floor(ref / 100) > 0 and band >= (threshold + 1) * floor(ref / 100)
  // floor(ref / 100) = ((ref >> 2) * RCP_MUL) >> RCP_SHIFT, with
  // RCP_MUL = ceil(2^51 / 25); exact for every 46-bit ref >> 2
  localparam int CHUNK_W    = 24;
  localparam int X_W        = ENERGY_W - 2;
  localparam int ACC_W      = 4 * CHUNK_W;
  localparam int RCP_SHIFT  = 51;
  localparam logic [2*CHUNK_W-1:0] RCP_MUL = 48'd90071992547410;
  // quotient of a 48-bit energy by 100 fits in 42 bits
  localparam int Q_W        = ENERGY_W - 6;
  localparam int QL_W       = Q_W / 2;
  localparam int QH_W       = Q_W - QL_W;
  localparam int THR1_W     = THR_W + 1;
  localparam int BOUND_W    = THR1_W + Q_W;

  // command queue
  localparam int FIFO_DEPTH = 4;

  // stream bus widths
  localparam int IN_TDATA_W  = 2 * SAMPLE_W;
  localparam int OUT_TDATA_W = 40;

  // command from the front end to the back end
  typedef struct packed {
    logic                fin;     // finalize the pending block
    logic                close;   // a block closed with these energies
    logic                flush;   // end of stream
    logic [ENERGY_W-1:0] ref_e;
    logic [ENERGY_W-1:0] band_e;
  } cmd_t;

  // one decision
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             mute;
    logic             last;
  } dec_t;

  // history bits 0 .. d + LOOK_BACK lie inside the window of a decision
  // that has d finalized blocks after it
  function automatic logic [WIN_W-1:0] win_mask(input logic [OWED_W-1:0] d);
    logic [WIN_W-1:0] m;
    for (int k = 0; k < WIN_W; k++) begin
      m[k] = (k <= int'(d) + LOOK_BACK);
    end
    return m;
  endfunction

endpackage

// File: sv/ebrmd_cmd_fifo.sv
// ---------------------------------------------------------------------------
// ebrmd_cmd_fifo
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module ebrmd_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ebrmd_pkg::cmd_t   din,
  output logic              full,
  input  logic              pop,
  output ebrmd_pkg::cmd_t   dout,
  output logic              empty
);
  import ebrmd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: sv/ebrmd_front.sv
// ---------------------------------------------------------------------------
// ebrmd_front
// Squares and accumulates samples, counts frames and turns frame and block
// boundaries and flushes into commands for the back end.
// ---------------------------------------------------------------------------
module ebrmd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ebrmd_pkg::SAMPLE_W-1:0]  ref_sample,
  input  logic [ebrmd_pkg::SAMPLE_W-1:0]  band_sample,
  input  logic                            frame_end,
  input  logic                            flush,
  input  logic [ebrmd_pkg::FPB_W-1:0]     frames_per_block,
  output logic                            cmd_push,
  output ebrmd_pkg::cmd_t                 cmd,
  input  logic                            cmd_full
);
  import ebrmd_pkg::*;

  // square stage
  logic                s1_valid_r, s1_valid_nxt;
  logic [SQ_W-1:0]     sq_ref_r, sq_ref_nxt;
  logic [SQ_W-1:0]     sq_band_r, sq_band_nxt;
  logic                fe_r, fe_nxt;
  logic                fl_r, fl_nxt;

  // accumulate stage
  logic [ENERGY_W-1:0] ref_acc_r, ref_acc_nxt;
  logic [ENERGY_W-1:0] band_acc_r, band_acc_nxt;
  logic [FPB_W-1:0]    frame_cnt_r, frame_cnt_nxt;
  logic                pend_r, pend_nxt;

  logic signed [SAMPLE_BITS-1:0] ref_s, band_s;
  logic signed [SQ_W-1:0]        ref_sq, band_sq;
  logic [ENERGY_W:0]             ref_sum_w, band_sum_w;
  logic [ENERGY_W-1:0]           ref_sum, band_sum;
  logic [FPB_W-1:0]              frame_inc;
  logic                          advance, fin, close;

  assign ref_s    = signed'(ref_sample[SAMPLE_BITS-1:0]);
  assign band_s   = signed'(band_sample[SAMPLE_BITS-1:0]);
  assign ref_sq   = ref_s * ref_s;
  assign band_sq  = band_s * band_s;

  assign advance  = s1_valid_r && !cmd_full;
  assign in_ready = !s1_valid_r || !cmd_full;

  // saturating sums of squares
  assign ref_sum_w  = {1'b0, ref_acc_r} + {{(ENERGY_W + 1 - SQ_W){1'b0}}, sq_ref_r};
  assign band_sum_w = {1'b0, band_acc_r} + {{(ENERGY_W + 1 - SQ_W){1'b0}}, sq_band_r};
  assign ref_sum    = ref_sum_w[ENERGY_W] ? '1 : ref_sum_w[ENERGY_W-1:0];
  assign band_sum   = band_sum_w[ENERGY_W] ? '1 : band_sum_w[ENERGY_W-1:0];

  // a length of zero closes after the counter wraps
  assign frame_inc = frame_cnt_r + 1'b1;
  assign fin       = !fl_r && fe_r && pend_r;
  assign close     = !fl_r && fe_r && (frame_inc == frames_per_block);

  assign cmd.fin    = fin;
  assign cmd.close  = close;
  assign cmd.flush  = fl_r;
  assign cmd.ref_e  = ref_sum;
  assign cmd.band_e = band_sum;
  assign cmd_push   = advance && (fin || close || fl_r);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    sq_ref_nxt   = sq_ref_r;
    sq_band_nxt  = sq_band_r;
    fe_nxt       = fe_r;
    fl_nxt       = fl_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
      sq_ref_nxt   = SQ_W'(ref_sq);
      sq_band_nxt  = SQ_W'(band_sq);
      fe_nxt       = frame_end;
      fl_nxt       = flush;
    end

    ref_acc_nxt   = ref_acc_r;
    band_acc_nxt  = band_acc_r;
    frame_cnt_nxt = frame_cnt_r;
    pend_nxt      = pend_r;
    if (advance) begin
      if (fl_r) begin
        ref_acc_nxt   = '0;
        band_acc_nxt  = '0;
        frame_cnt_nxt = '0;
        pend_nxt      = 1'b0;
      end else begin
        ref_acc_nxt  = ref_sum;
        band_acc_nxt = band_sum;
        if (fe_r) begin
          frame_cnt_nxt = frame_inc;
        end
        if (fin) begin
          pend_nxt = 1'b0;
        end
        if (close) begin
          ref_acc_nxt   = '0;
          band_acc_nxt  = '0;
          frame_cnt_nxt = '0;
          pend_nxt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      ref_acc_r   <= '0;
      band_acc_r  <= '0;
      frame_cnt_r <= '0;
      pend_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      ref_acc_r   <= ref_acc_nxt;
      band_acc_r  <= band_acc_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_ref_r  <= sq_ref_nxt;
    sq_band_r <= sq_band_nxt;
    fe_r      <= fe_nxt;
    fl_r      <= fl_nxt;
  end

endmodule

// File: sv/ebrmd_back.sv
// ---------------------------------------------------------------------------
// ebrmd_back
// Executes commands: loudness test of closed blocks, loudness history,
// mute decisions and the flush drain, into a registered output.
// ---------------------------------------------------------------------------
module ebrmd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  ebrmd_pkg::cmd_t                 cmd,
  output logic                            cmd_pop,
  input  logic [ebrmd_pkg::FLOOR_W-1:0]   energy_floor,
  input  logic [ebrmd_pkg::THR_W-1:0]     level_threshold,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ebrmd_pkg::dec_t                 out_dec
);
  import ebrmd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RCP   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [WIN_W-1:0]     hist_r, hist_nxt;
  logic [OWED_W-1:0]    owed_r, owed_nxt;
  logic [IDX_W-1:0]     emitted_r, emitted_nxt;
  logic                 loud_r, loud_nxt;

  logic [X_W-1:0]       x_r, x_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [ENERGY_W-1:0]  band_r, band_nxt;
  logic                 q_nz_r, q_nz_nxt;
  logic [THR1_W+QH_W-1:0] prod_hi_r, prod_hi_nxt;
  logic [THR1_W+QL_W-1:0] prod_lo_r, prod_lo_nxt;
  logic [BOUND_W-1:0]   bound_r, bound_nxt;

  logic                 out_valid_r, out_valid_nxt;
  dec_t                 out_dec_r, out_dec_nxt;

  logic                 out_free;
  logic [WIN_W-1:0]     hist_shift;
  logic [OWED_W-1:0]    owed_inc;
  logic [ENERGY_W-1:0]  floor_ext;
  logic [ENERGY_W-1:0]  ref_floored;
  logic [CHUNK_W-1:0]   op_x, op_m;
  logic [2*CHUNK_W-1:0] pp;
  logic [ACC_W-1:0]     pp_ext, part;
  logic [Q_W-1:0]       quo;
  logic [THR1_W-1:0]    thr1;

  assign out_free    = !out_valid_r || out_ready;
  assign hist_shift  = {hist_r[WIN_W-2:0], loud_r};
  assign owed_inc    = owed_r + 1'b1;
  assign floor_ext   = {{(ENERGY_W - FLOOR_W){1'b0}}, energy_floor};
  assign ref_floored = (cmd.ref_e < floor_ext) ? floor_ext : cmd.ref_e;
  assign thr1        = {1'b0, level_threshold} + 1'b1;

  // one 24x24 partial product of (ref >> 2) * RCP_MUL per step
  assign op_x   = step_r[1] ? CHUNK_W'(x_r[X_W-1:CHUNK_W]) : x_r[CHUNK_W-1:0];
  assign op_m   = step_r[0] ? RCP_MUL[2*CHUNK_W-1:CHUNK_W] : RCP_MUL[CHUNK_W-1:0];
  assign pp     = op_x * op_m;
  assign pp_ext = {{(ACC_W - 2*CHUNK_W){1'b0}}, pp};
  assign part   = (step_r == 2'd0) ? pp_ext :
                  (step_r == 2'd3) ? (pp_ext << (2 * CHUNK_W)) : (pp_ext << CHUNK_W);
  assign quo    = acc_r[RCP_SHIFT +: Q_W];

  assign out_valid  = out_valid_r;
  assign out_dec    = out_dec_r;

  always_comb begin
    state_nxt     = state_r;
    hist_nxt      = hist_r;
    owed_nxt      = owed_r;
    emitted_nxt   = emitted_r;
    loud_nxt      = loud_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    band_nxt      = band_r;
    q_nz_nxt      = q_nz_r;
    prod_hi_nxt   = prod_hi_r;
    prod_lo_nxt   = prod_lo_r;
    bound_nxt     = bound_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dec_nxt   = out_dec_r;
    cmd_pop       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.fin) begin
            hist_nxt = hist_shift;
            owed_nxt = owed_inc;
            // look-ahead complete for the oldest owed block
            if (owed_inc == OWED_W'(LOOK_AHEAD + 1)) begin
              out_valid_nxt     = 1'b1;
              out_dec_nxt.index = emitted_r;
              out_dec_nxt.mute  = |(hist_shift & win_mask(OWED_W'(LOOK_AHEAD)));
              out_dec_nxt.last  = 1'b0;
              emitted_nxt       = emitted_r + 1'b1;
              owed_nxt          = owed_r;
            end
          end
          if (cmd.close) begin
            x_nxt     = ref_floored[ENERGY_W-1:2];
            acc_nxt   = '0;
            step_nxt  = '0;
            band_nxt  = cmd.band_e;
            state_nxt = ST_RCP;
          end
          if (cmd.flush) begin
            if (owed_r == '0) begin
              hist_nxt    = '0;
              emitted_nxt = '0;
              loud_nxt    = 1'b0;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      // divide by 100 as a reciprocal multiply, four steps
      ST_RCP: begin
        acc_nxt  = acc_r + part;
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd3) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        q_nz_nxt    = |quo;
        prod_hi_nxt = (THR1_W + QH_W)'(thr1) * (THR1_W + QH_W)'(quo[Q_W-1:QL_W]);
        prod_lo_nxt = (THR1_W + QL_W)'(thr1) * (THR1_W + QL_W)'(quo[QL_W-1:0]);
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        bound_nxt = {prod_hi_r, {QL_W{1'b0}}} + BOUND_W'(prod_lo_r);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        loud_nxt  = q_nz_r && (BOUND_W'(band_r) >= bound_r);
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_dec_nxt.index = emitted_r;
          out_dec_nxt.mute  = |(hist_r & win_mask(owed_r - 1'b1));
          out_dec_nxt.last  = (owed_r == OWED_W'(1));
          emitted_nxt       = emitted_r + 1'b1;
          owed_nxt          = owed_r - 1'b1;
          if (owed_r == OWED_W'(1)) begin
            hist_nxt    = '0;
            emitted_nxt = '0;
            loud_nxt    = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hist_r      <= '0;
      owed_r      <= '0;
      emitted_r   <= '0;
      loud_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      owed_r      <= owed_nxt;
      emitted_r   <= emitted_nxt;
      loud_r      <= loud_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    acc_r     <= acc_nxt;
    step_r    <= step_nxt;
    band_r    <= band_nxt;
    q_nz_r    <= q_nz_nxt;
    prod_hi_r <= prod_hi_nxt;
    prod_lo_r <= prod_lo_nxt;
    bound_r   <= bound_nxt;
    out_dec_r <= out_dec_nxt;
  end

endmodule

// File: sv/block_energy_ratio_mute_detector_unit.sv
// ---------------------------------------------------------------------------
// block_energy_ratio_mute_detector_unit
// Per-block band/reference energy ratio, loudness test and windowed mute
// decisions over neighboring blocks.
// ---------------------------------------------------------------------------
//  bus   dir  payload                                   handshake
//  in_   in   tdata {band, ref}, tlast frame_end,       tvalid/tready
//             tuser flush
//  out_  out  tdata {mute, block_index}, tlast last     tvalid/tready
//  cfg_  in   addr, wdata                               we, no wait
//
//  one sample per cycle as long as the command queue has room
//  a block close holds the back end for 4 multiply-accumulate
//  steps for the divide by 100, then multiply, add and compare
//  a flush drains owed decisions at one per cycle while the output is free
//  synchronous active-low reset, no clearing pass
//  either side may stall; the output register holds a decision until taken
// ---------------------------------------------------------------------------
module block_energy_ratio_mute_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ebrmd_pkg::IN_TDATA_W-1:0]     in_tdata,   // ref_sample, band_sample
  input  logic                                 in_tlast,
  input  logic                                 in_tuser,   // flush
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ebrmd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // block_index, mute, zero pad
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [ebrmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ebrmd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ebrmd_pkg::*;

  logic [FPB_W-1:0]   frames_per_block_r;
  logic [FLOOR_W-1:0] energy_floor_r;
  logic [THR_W-1:0]   level_threshold_r;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  dec_t dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_per_block_r <= FPB_RESET;
      energy_floor_r     <= FLOOR_RESET;
      level_threshold_r  <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAMES: frames_per_block_r <= cfg_wdata[FPB_W-1:0];
        CFG_FLOOR:  energy_floor_r     <= cfg_wdata[FLOOR_W-1:0];
        CFG_THRESH: level_threshold_r  <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ebrmd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .ref_sample       (in_tdata[SAMPLE_W-1:0]),
    .band_sample      (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .frame_end        (in_tlast),
    .flush            (in_tuser),
    .frames_per_block (frames_per_block_r),
    .cmd_push         (cmd_push),
    .cmd              (cmd_in),
    .cmd_full         (cmd_full)
  );

  ebrmd_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  ebrmd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (!cmd_empty),
    .cmd             (cmd_out),
    .cmd_pop         (cmd_pop),
    .energy_floor    (energy_floor_r),
    .level_threshold (level_threshold_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_dec         (dec)
  );

  assign out_tdata = {{(OUT_TDATA_W - IDX_W - 1){1'b0}}, dec.mute, dec.index};
  assign out_tlast = dec.last;

endmodule

// File: sv/ebrmd_checker.sv
// ---------------------------------------------------------------------------
// ebrmd_checker
// Port-level checks of the mute detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ebrmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // a stalled decision holds
  `ASSERT_ON(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled decision changed")

  // reset leaves no decision pending and the input open
  `ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")

  // back-to-back decisions inside a run carry consecutive block indexes
  `ASSERT_ON(a_idx_step, clk, rst_n, (out_tvalid && out_tready && !out_tlast) ##1 (out_tvalid && out_tready) |-> out_tdata[31:0] == $past(out_tdata[31:0]) + 32'd1, "block index skipped")

endmodule

bind block_energy_ratio_mute_detector_unit ebrmd_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
